// File: src/mlfp_pkg.sv
// shared types and constants of the masked laplace fill pass
package mlfp_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	// task queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// register reset values
	localparam logic [15:0] CORR_RESET   = 16'd13107;
	localparam logic [10:0] WIDTH_RESET  = 11'd1024;
	localparam logic [15:0] HEIGHT_RESET = 16'd1024;

	// configuration register indexes
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;
	localparam logic [CFG_IW-1:0] CFG_CORR_FACTOR  = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 2'd2;

	// request opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [31:0] pixel_value;
		logic               masked;
	} pix_req_t;

	typedef struct packed {
		logic signed [31:0] corrected_value;
		logic               last_pixel;
		logic [31:0]        peak_error;
	} result_t;

	// one line store word
	typedef struct packed {
		logic signed [31:0] value;
		logic               mask;
	} store_word_t;

	// one stencil column: rows above, current, below
	typedef struct packed {
		logic signed [31:0] up;
		logic signed [31:0] mid;
		logic signed [31:0] down;
		logic               mask_up;
		logic               mask_mid;
	} column_t;

	typedef struct packed {
		logic interior;
		logic col_first;
		logic col_last;
		logic width_two;
		logic row_top;
		logic row_bottom;
		logic height_two;
		logic last;
	} class_t;

	// right holds the left column when the pixel ends its row
	typedef struct packed {
		class_t  cls;
		column_t cen;
		column_t right;
	} task_t;

endpackage

// File: src/mlfp_ram.sv
// generic one write, two read port ram with registered read
module mlfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: src/mlfp_front.sv
// front end: request intake, line store ring, stencil fetch and classification
module mlfp_front #(
	parameter int MAX_WIDTH = mlfp_pkg::MAX_WIDTH_DEF,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int PW = $clog2(MAX_WIDTH + 3)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_stall,
	input  mlfp_pkg::pix_req_t     pix_req,
	input  logic [10:0]            frame_width,
	input  logic [15:0]            frame_height,
	input  logic                   restart,
	input  logic [mlfp_pkg::QCW-1:0] q_count,
	output logic                   push,
	output mlfp_pkg::task_t        push_task
);
	import mlfp_pkg::*;

	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	logic          accept, is_pix, do_emit;

	logic [CW-1:0] col_q, ecol_q;
	logic [15:0]   row_q, erow_q;
	logic [1:0]    wslot_q, eslot_q;
	logic [PW-1:0] pend_q;

	logic [WW-1:0] c_ext;
	logic          c_first, c_last, r_first, r_last, w_ge2, h_ge2;
	class_t        cls;
	logic [CW-1:0] rda, rdb;

	logic          emit_s1, wr_valid_s1;
	class_t        cls_s1;
	logic [1:0]    eslot_s1, wr_slot_s1;
	logic [CW-1:0] rda_s1, rdb_s1, wr_col_s1;
	store_word_t   wr_word_s1;

	logic [3:0]    we;
	store_word_t   wdata;
	store_word_t   ram_a [4];
	store_word_t   ram_b [4];
	store_word_t   word_a [4];
	store_word_t   word_b [4];
	logic [1:0]    up_slot, dn_slot;

	assign w_eff = (frame_width == 11'd0) ? WW'(1) :
		(32'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
	assign h_eff = (frame_height == 16'd0) ? 16'd1 : frame_height;

	// room for the front stage task plus the one being accepted
	assign pix_stall = ((QCW+1)'(q_count) + (QCW+1)'(emit_s1)) >= (QCW+1)'(QDEPTH);
	assign accept    = pix_valid && !pix_stall;
	assign is_pix    = accept && (pix_req.op == OP_PIXEL);
	assign do_emit   = accept && ((pix_req.op == OP_DRAIN) ? (pend_q != '0)
		: (pend_q > PW'(w_eff)));

	// classify the pixel about to leave
	always_comb begin
		c_ext   = WW'(ecol_q);
		c_first = (ecol_q == '0);
		c_last  = (c_ext == (w_eff - WW'(1)));
		r_first = (erow_q == 16'd0);
		r_last  = (erow_q == (h_eff - 16'd1));
		w_ge2   = (w_eff != WW'(1));
		h_ge2   = (h_eff != 16'd1);
		cls.interior   = !r_first && (({1'b0, erow_q} + 17'd1) < {1'b0, h_eff})
			&& !c_first && ((c_ext + WW'(1)) < w_eff);
		cls.col_first  = w_ge2 && c_first;
		cls.col_last   = w_ge2 && c_last;
		cls.width_two  = (w_eff == WW'(2)) && w_ge2;
		cls.row_top    = h_ge2 && r_first;
		cls.row_bottom = h_ge2 && r_last;
		cls.height_two = (h_eff == 16'd2);
		cls.last       = r_last && c_last;
		rda = ecol_q;
		// at the row end the second port fetches the left column
		rdb = c_last ? (ecol_q - CW'(1)) : CW'(c_ext + WW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			wslot_q     <= '0;
			ecol_q      <= '0;
			erow_q      <= '0;
			eslot_q     <= '0;
			pend_q      <= '0;
			emit_s1     <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else if (restart) begin
			col_q       <= '0;
			row_q       <= '0;
			wslot_q     <= '0;
			ecol_q      <= '0;
			erow_q      <= '0;
			eslot_q     <= '0;
			pend_q      <= '0;
			emit_s1     <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else begin
			emit_s1     <= do_emit;
			wr_valid_s1 <= is_pix;
			if (is_pix) begin
				if ((WW'(col_q) + WW'(1)) >= w_eff) begin
					col_q   <= '0;
					wslot_q <= wslot_q + 2'd1;
					row_q   <= (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff}) ? 16'd0
						: row_q + 16'd1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (do_emit) begin
				if ((c_ext + WW'(1)) >= w_eff) begin
					ecol_q  <= '0;
					eslot_q <= eslot_q + 2'd1;
					erow_q  <= (({1'b0, erow_q} + 17'd1) >= {1'b0, h_eff}) ? 16'd0
						: erow_q + 16'd1;
				end else begin
					ecol_q <= ecol_q + CW'(1);
				end
			end
			pend_q <= pend_q + PW'(is_pix) - PW'(do_emit);
		end
	end

	always_ff @(posedge clk) begin
		cls_s1     <= cls;
		eslot_s1   <= eslot_q;
		rda_s1     <= rda;
		rdb_s1     <= rdb;
		wr_slot_s1 <= wslot_q;
		wr_col_s1  <= col_q;
		wr_word_s1 <= wdata;
	end

	assign wdata = '{value: pix_req.pixel_value, mask: pix_req.masked};

	for (genvar g = 0; g < 4; g++) begin : g_line
		assign we[g] = is_pix && (wslot_q == 2'(g));
		mlfp_ram #(
			.WIDTH($bits(store_word_t)),
			.DEPTH(MAX_WIDTH)
		) u_ram (
			.clk    (clk),
			.we     (we[g]),
			.waddr  (col_q),
			.wdata  (wdata),
			.raddr_a(rda),
			.rdata_a(ram_a[g]),
			.raddr_b(rdb),
			.rdata_b(ram_b[g])
		);
	end

	// forward the write that landed in the same cycle as the read
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			word_a[j] = (wr_valid_s1 && (wr_slot_s1 == 2'(j)) && (wr_col_s1 == rda_s1))
				? wr_word_s1 : ram_a[j];
			word_b[j] = (wr_valid_s1 && (wr_slot_s1 == 2'(j)) && (wr_col_s1 == rdb_s1))
				? wr_word_s1 : ram_b[j];
		end
		up_slot = eslot_s1 - 2'd1;
		dn_slot = eslot_s1 + 2'd1;
		push_task.cls            = cls_s1;
		push_task.cen.up         = word_a[up_slot].value;
		push_task.cen.mid        = word_a[eslot_s1].value;
		push_task.cen.down       = word_a[dn_slot].value;
		push_task.cen.mask_up    = word_a[up_slot].mask;
		push_task.cen.mask_mid   = word_a[eslot_s1].mask;
		push_task.right.up       = word_b[up_slot].value;
		push_task.right.mid      = word_b[eslot_s1].value;
		push_task.right.down     = word_b[dn_slot].value;
		push_task.right.mask_up  = word_b[up_slot].mask;
		push_task.right.mask_mid = word_b[eslot_s1].mask;
	end

	assign push = emit_s1;

endmodule

// File: src/mlfp_queue.sv
// short task queue between front and back
module mlfp_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  mlfp_pkg::task_t          push_task,
	input  logic                     pop,
	output logic                     not_empty,
	output mlfp_pkg::task_t          head,
	output logic [mlfp_pkg::QCW-1:0] count
);
	import mlfp_pkg::*;

	task_t          ent_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_task;
		end
	end

	assign head      = ent_q[rptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCW'(QDEPTH)))
		else $error("task queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("task queue underflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCW'(1)))
		else $error("task queue count lost a push");
`endif

endmodule

// File: src/mlfp_back.sv
// back end: stencil arithmetic, border copy, saturation and frame error maximum
module mlfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       corr_factor,
	input  logic              restart,
	input  logic              q_valid,
	input  mlfp_pkg::task_t   q_head,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_stall,
	output mlfp_pkg::result_t res_data
);
	import mlfp_pkg::*;

	localparam logic signed [36:0] SAT_HI = 37'(32'sh7FFF_FFFF);
	localparam logic signed [36:0] SAT_LO = 37'(32'sh8000_0000);

	// border copy along the rows for one column
	function automatic logic signed [31:0] row_pick(column_t col, class_t c);
		logic signed [31:0] v;
		if (col.mask_mid && c.row_top) begin
			v = col.down;
		end else if (col.mask_mid && c.row_bottom) begin
			v = (c.height_two && col.mask_up) ? col.mid : col.up;
		end else begin
			v = col.mid;
		end
		return v;
	endfunction

	logic               adv;
	column_t            left_q;
	column_t            cen;
	class_t             cls;
	logic signed [34:0] lap;
	logic signed [31:0] base;
	logic               apply;

	logic               valid_s1, apply_s1, last_s1;
	logic signed [34:0] lap_s1;
	logic signed [31:0] base_s1;
	logic               valid_s2, apply_s2, last_s2;
	logic signed [51:0] prod_s2;
	logic signed [31:0] base_s2;
	logic signed [16:0] cf_s;

	logic signed [35:0] cor;
	logic signed [36:0] sum;
	logic [35:0]        mag;
	logic [31:0]        m32, new_max, run_q;
	logic signed [31:0] value;

	assign adv = !res_valid || !res_stall;
	assign pop = adv && q_valid;
	assign cf_s = {1'b0, corr_factor};

	always_comb begin
		cen = q_head.cen;
		cls = q_head.cls;
		lap = 35'(cen.up) + 35'(cen.down) + 35'(left_q.mid) + 35'(q_head.right.mid)
			- (35'(cen.mid) <<< 2);
		apply = cen.mask_mid && cls.interior;
		if (!cen.mask_mid || cls.interior) begin
			base = cen.mid;
		end else if (cls.col_first) begin
			base = row_pick(q_head.right, cls);
		end else if (cls.col_last) begin
			// left column fetched with this pixel; with two columns its mask picks
			base = (cls.width_two && q_head.right.mask_mid) ? row_pick(cen, cls)
				: row_pick(q_head.right, cls);
		end else begin
			base = row_pick(cen, cls);
		end
	end

	always_comb begin
		cor = prod_s2[51:16];
		sum = 37'(base_s2) + 37'(cor);
		mag = cor[35] ? 36'(-cor) : 36'(cor);
		m32 = (mag[35:32] != 4'd0) ? 32'hFFFF_FFFF : mag[31:0];
		new_max = (apply_s2 && (m32 > run_q)) ? m32 : run_q;
		if (!apply_s2) begin
			value = base_s2;
		end else if (sum > SAT_HI) begin
			value = 32'sh7FFF_FFFF;
		end else if (sum < SAT_LO) begin
			value = 32'sh8000_0000;
		end else begin
			value = sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res_valid <= 1'b0;
			run_q     <= '0;
		end else if (restart) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			res_valid <= 1'b0;
			run_q     <= '0;
		end else if (adv) begin
			valid_s1  <= q_valid;
			valid_s2  <= valid_s1;
			res_valid <= valid_s2;
			if (valid_s2) begin
				run_q <= last_s2 ? 32'd0 : new_max;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_valid) begin
				left_q <= q_head.cen;
			end
			apply_s1 <= apply;
			lap_s1   <= lap;
			base_s1  <= base;
			last_s1  <= cls.last;
			apply_s2 <= apply_s1;
			prod_s2  <= 52'(lap_s1) * 52'(cf_s);
			base_s2  <= base_s1;
			last_s2  <= last_s1;
			res_data.corrected_value <= value;
			res_data.last_pixel      <= last_s2;
			res_data.peak_error      <= last_s2 ? new_max : 32'd0;
		end
	end

endmodule

// File: src/masked_laplace_fill_pass.sv
// top level of the masked laplace fill pass
//
//  channel | direction | handshake           | payload
//  pixel   | in        | pix_valid/pix_stall | pix_req  (op, pixel_value, masked)
//  result  | out       | res_valid/res_stall | res_data (corrected_value, last_pixel,
//          |           |                     |           peak_error)
//  config  | in        | cfg_we              | cfg_index, cfg_data
//
// one request per cycle while pix_stall is low; a pixel's result leaves frame_width+1
// requests later and reaches res_valid through, in order, the front fetch stage, the task
// queue, two arithmetic stages and the result register
// reset clears positions, pending count and error maximum; line stores are not cleared
// pix_stall rises when the task queue and the front stage together hold four tasks
module masked_laplace_fill_pass #(
	parameter int MAX_WIDTH = mlfp_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  mlfp_pkg::pix_req_t          pix_req,
	output logic                        res_valid,
	input  logic                        res_stall,
	output mlfp_pkg::result_t           res_data,
	input  logic                        cfg_we,
	input  logic [mlfp_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mlfp_pkg::CFG_DW-1:0] cfg_data
);
	import mlfp_pkg::*;

	logic [15:0]    corr_q;
	logic [10:0]    width_q;
	logic [15:0]    height_q;
	logic           restart;
	logic           push, pop, q_valid;
	task_t          push_task, q_head;
	logic [QCW-1:0] q_count;

	// geometry writes restart the stream
	assign restart = cfg_we && (cfg_index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q   <= CORR_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CORR_FACTOR:  corr_q   <= cfg_data;
				CFG_FRAME_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mlfp_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix_req     (pix_req),
		.frame_width (width_q),
		.frame_height(height_q),
		.restart     (restart),
		.q_count     (q_count),
		.push        (push),
		.push_task   (push_task)
	);

	mlfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_task(push_task),
		.pop      (pop),
		.not_empty(q_valid),
		.head     (q_head),
		.count    (q_count)
	);

	mlfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.corr_factor(corr_q),
		.restart    (restart),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

endmodule
